[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CHK_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checked on every edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

[hdl/b64e_pkg.sv]
`timescale 1ns / 1ps
package b64e_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int ADDR_W = 3;
  localparam logic [0:0] REG_CHAR_OFFSET = 1'b0;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef enum logic [1:0] {PH_EMPTY, PH_ONE, PH_TWO} phase_t;
  typedef enum logic [1:0] {FILL_ONE, FILL_TWO, FILL_THREE} fill_t;
  typedef enum logic [1:0] {POS_FIRST, POS_SECOND, POS_THIRD, POS_FOURTH} pos_t;

  typedef struct packed {
    logic [23:0] word;
    fill_t       fill;
    logic        eom;
  } group_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] six, input logic offset);
    logic [7:0] c;
    priority if (six < 6'd26) c = 8'd65 + {2'b00, six};
    else if (six < 6'd52) c = 8'd71 + {2'b00, six};
    else if (six < 6'd62) c = {2'b00, six} - 8'd4;
    else if (six == 6'd62) c = 8'd43;
    else c = 8'd47;
    return c + {7'b0, offset};
  endfunction

endpackage

[hdl/b64e_front.sv]
`timescale 1ns / 1ps
module b64e_front import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  input  logic       q_full,
  output logic       push,
  output group_t     push_group
);

  phase_t      phase, phase_next;
  logic [15:0] held;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_EMPTY: phase_next = end_of_message ? PH_EMPTY : PH_ONE;
        PH_ONE:   phase_next = end_of_message ? PH_EMPTY : PH_TWO;
        PH_TWO:   phase_next = PH_EMPTY;
        default:  phase_next = PH_EMPTY;
      endcase
    end
  end

  always_comb begin
    push            = 1'b0;
    push_group.eom  = end_of_message;
    push_group.word = {data_byte, 16'h0000};
    push_group.fill = FILL_ONE;
    unique case (phase)
      PH_ONE: begin
        push_group.word = {held[7:0], data_byte, 8'h00};
        push_group.fill = FILL_TWO;
        push            = accept && end_of_message;
      end
      PH_TWO: begin
        push_group.word = {held, data_byte};
        push_group.fill = FILL_THREE;
        push            = accept;
      end
      default: begin
        push = accept && end_of_message;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_EMPTY;
    end else begin
      phase <= phase_next;
    end
  end

  // shift the new byte in; only the bytes counted by phase are ever used
  always_ff @(posedge clk) begin
    if (accept) begin
      held <= {held[7:0], data_byte};
    end
  end

endmodule

[hdl/b64e_queue.sv]
`timescale 1ns / 1ps
module b64e_queue import b64e_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  group_t push_group,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output group_t head
);

  group_t              entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_group;
    end
  end

endmodule

[hdl/b64e_back.sv]
`timescale 1ns / 1ps
module b64e_back import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_offset,
  input  logic       head_valid,
  input  group_t     head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       last_of_group,
  output logic       last_of_message
);

  group_t     cur;
  logic       cur_valid;
  pos_t       pos, pos_next;
  logic       advance;
  logic       at_end;
  logic [5:0] six;
  logic       pad;
  logic [7:0] char_sel;

  assign advance = cur_valid && (!out_valid || out_ready);
  assign at_end  = (pos == POS_FOURTH);
  assign pop     = head_valid && (!cur_valid || (advance && at_end));

  always_comb begin
    pos_next = pos;
    if (advance) begin
      unique case (pos)
        POS_FIRST:  pos_next = POS_SECOND;
        POS_SECOND: pos_next = POS_THIRD;
        POS_THIRD:  pos_next = POS_FOURTH;
        POS_FOURTH: pos_next = POS_FIRST;
      endcase
    end
  end

  always_comb begin
    six = cur.word[23:18];
    pad = 1'b0;
    unique case (pos)
      POS_FIRST:  six = cur.word[23:18];
      POS_SECOND: six = cur.word[17:12];
      POS_THIRD: begin
        six = cur.word[11:6];
        pad = (cur.fill == FILL_ONE);
      end
      POS_FOURTH: begin
        six = cur.word[5:0];
        pad = (cur.fill != FILL_THREE);
      end
    endcase
    char_sel = pad ? PAD_CHAR : sextet_char(six, char_offset);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_FIRST;
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pos <= pos_next;
      if (pop) cur_valid <= 1'b1;
      else if (advance && at_end) cur_valid <= 1'b0;
      if (advance) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (advance) begin
      out_char        <= char_sel;
      last_of_group   <= at_end;
      last_of_message <= at_end && cur.eom;
    end
  end

endmodule

[hdl/base64_stream_encoder.sv]
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// in       sink       in_valid / in_ready  data_byte, end_of_message
// out      source     out_valid/out_ready  out_char, last_of_group, last_of_message
// cfg      APB slave  psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// A byte is taken every cycle while the two-entry group queue has room.
// The character stage sends one character per cycle while out_ready holds and a group is
// queued, four per group, so the output side sets the sustained byte rate.
// The closing byte's group goes through the queue entry, cur and the output register in turn.
// Reset (synchronous) empties the open group, the queue, the output and char_offset.
// A stalled output holds its character; the front keeps filling the queue meanwhile.
module base64_stream_encoder import b64e_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              end_of_message,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_char,
  output logic              last_of_group,
  output logic              last_of_message,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic   char_offset;
  logic   push, q_full, pop, head_valid;
  group_t push_group, head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CHAR_OFFSET) ? {31'b0, char_offset} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_offset <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CHAR_OFFSET)) begin
      char_offset <= pwdata[0];
    end
  end

  b64e_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .q_full         (q_full),
    .push           (push),
    .push_group     (push_group)
  );

  b64e_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  b64e_back u_back (
    .clk             (clk),
    .rst             (rst),
    .char_offset     (char_offset),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .last_of_group   (last_of_group),
    .last_of_message (last_of_message)
  );

endmodule

[hdl/b64e_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module b64e_checker import b64e_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       last_of_group,
  input logic       last_of_message
);

  logic stalled;
  logic msg_end_seen;
  logic pad_mid;

  assign stalled      = out_valid && !out_ready;
  assign msg_end_seen = out_valid && last_of_message;
  // a pad before the fourth character is always followed by the closing pad
  assign pad_mid      = out_valid && out_ready && !last_of_group && (out_char == PAD_CHAR);

  `CHK_ASSERT_ALWAYS(a_reset_drops_output, rst |=> !out_valid, "output valid after reset")
  `CHK_ASSERT(a_out_hold, stalled |=> out_valid && $stable(out_char), "stalled item changed")
  `CHK_ASSERT(a_msg_end_on_quartet, msg_end_seen |-> last_of_group, "message end off quartet")
  `CHK_ASSERT(a_pad_then_pad, pad_mid |=> !out_valid || out_char == PAD_CHAR, "char after pad")

endmodule

bind base64_stream_encoder b64e_checker u_chk (.*);
